>>> rtl/bpad_pkg.sv
package bpad_pkg;

    localparam int DEFAULT_MAX_VALUES = 1024;
    localparam int VALUE_COUNT_W      = 11;
    localparam int BYTE_W             = 8;
    localparam int STORE_W            = 56;
    localparam int VALUE_W            = 64;
    localparam int HALF_W             = 32;
    localparam int PLANE_W            = 3;
    localparam int INDEX_OUT_W        = 10;

    localparam logic [PLANE_W-1:0] LAST_PLANE_NARROW = 3'd3;
    localparam logic [PLANE_W-1:0] LAST_PLANE_WIDE   = 3'd7;

    typedef enum logic [1:0] {
        KIND_INT32 = 2'd0,
        KIND_INT64 = 2'd1,
        KIND_FLOAT = 2'd2,
        KIND_REF   = 2'd3
    } kind_t;

    typedef enum logic {
        REG_VALUE_COUNT = 1'b0,
        REG_VALUE_KIND  = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic  valid;
        logic  first_plane;
        logic  final_plane;
        logic  last_index;
        kind_t kind;
    } stage_t;

endpackage

>>> rtl/bpad_ram.sv
module bpad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/bpad_seq.sv
module bpad_seq #(
    parameter int MAX_VALUES = 1024,
    parameter int IDX_W      = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  bpad_pkg::reg_index_t                 cfg_index,
    input  logic [bpad_pkg::VALUE_COUNT_W-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [bpad_pkg::BYTE_W-1:0]          data_byte,
    input  logic                                 advance,
    output logic                                 rd_en,
    output logic [IDX_W-1:0]                     rd_addr,
    output bpad_pkg::stage_t                     stg,
    output logic [IDX_W-1:0]                     stg_idx,
    output logic [bpad_pkg::BYTE_W-1:0]          stg_byte,
    output logic                                 cfg_clear
);

    import bpad_pkg::*;

    localparam int CNT_CLOG = $clog2(MAX_VALUES + 1);
    localparam int CNT_W    = (CNT_CLOG > VALUE_COUNT_W) ? CNT_CLOG : VALUE_COUNT_W;

    logic [VALUE_COUNT_W-1:0] value_count_reg;
    kind_t                    value_kind_reg;
    logic [PLANE_W-1:0]       plane_reg, plane_next;
    logic [IDX_W-1:0]         index_reg, index_next;
    stage_t                   stg_reg, stg_next;
    logic [IDX_W-1:0]         stg_idx_reg;
    logic [BYTE_W-1:0]        stg_byte_reg;

    logic [CNT_W-1:0]   count_ext;
    logic [CNT_W-1:0]   count_max;
    logic [IDX_W-1:0]   last_idx;
    logic [IDX_W-1:0]   idx_eff;
    logic [PLANE_W-1:0] last_plane;
    logic               at_last_idx;
    logic               at_last_plane;
    logic               accept;

    assign count_ext = CNT_W'(value_count_reg);
    assign count_max = CNT_W'(MAX_VALUES);

    always_comb
    begin
        if (count_ext == '0)
        begin
            last_idx = '0;
        end
        else if (count_ext > count_max)
        begin
            last_idx = IDX_W'(count_max - CNT_W'(1));
        end
        else
        begin
            last_idx = IDX_W'(count_ext - CNT_W'(1));
        end
    end

    assign idx_eff       = (index_reg > last_idx) ? last_idx : index_reg;
    assign last_plane    = (value_kind_reg == KIND_INT64) ? LAST_PLANE_WIDE : LAST_PLANE_NARROW;
    assign at_last_idx   = (idx_eff == last_idx);
    assign at_last_plane = (plane_reg == last_plane);

    assign in_ready  = !stg_reg.valid || advance;
    assign accept    = in_valid && in_ready;
    assign rd_en     = accept;
    assign rd_addr   = idx_eff;
    assign cfg_clear = cfg_valid;

    always_comb
    begin
        plane_next = plane_reg;
        index_next = index_reg;
        if (cfg_valid)
        begin
            plane_next = '0;
            index_next = '0;
        end
        else if (accept)
        begin
            if (at_last_idx)
            begin
                index_next = '0;
                plane_next = at_last_plane ? '0 : plane_reg + PLANE_W'(1);
            end
            else
            begin
                index_next = idx_eff + IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        stg_next = stg_reg;
        if (accept)
        begin
            stg_next.valid       = 1'b1;
            stg_next.first_plane = (plane_reg == '0);
            stg_next.final_plane = at_last_plane;
            stg_next.last_index  = at_last_idx;
            stg_next.kind        = value_kind_reg;
        end
        else if (advance)
        begin
            stg_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_count_reg <= VALUE_COUNT_W'(1);
            value_kind_reg  <= KIND_INT32;
            plane_reg       <= '0;
            index_reg       <= '0;
            stg_reg         <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_VALUE_COUNT: value_count_reg <= cfg_data;
                    REG_VALUE_KIND:  value_kind_reg  <= kind_t'(cfg_data[1:0]);
                    default:         value_count_reg <= value_count_reg;
                endcase
            end
            plane_reg <= plane_next;
            index_reg <= index_next;
            stg_reg   <= stg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_idx_reg  <= idx_eff;
            stg_byte_reg <= data_byte;
        end
    end

    assign stg      = stg_reg;
    assign stg_idx  = stg_idx_reg;
    assign stg_byte = stg_byte_reg;

endmodule

>>> rtl/bpad_dp.sv
module bpad_dp #(
    parameter int IDX_W = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bpad_pkg::stage_t                    stg,
    input  logic [IDX_W-1:0]                    stg_idx,
    input  logic [bpad_pkg::BYTE_W-1:0]         stg_byte,
    input  logic [bpad_pkg::STORE_W-1:0]        rd_data,
    input  logic                                cfg_clear,
    output logic                                advance,
    output logic                                wr_en,
    output logic [IDX_W-1:0]                    wr_addr,
    output logic [bpad_pkg::STORE_W-1:0]        wr_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bpad_pkg::VALUE_W-1:0]        value_bits,
    output logic [bpad_pkg::INDEX_OUT_W-1:0]    value_index,
    output logic                                last_value
);

    import bpad_pkg::*;

    logic                   fwd_valid_reg;
    logic [IDX_W-1:0]       fwd_addr_reg;
    logic [STORE_W-1:0]     fwd_data_reg;
    logic [HALF_W-1:0]      sum_reg, sum_next;
    logic                   out_valid_reg;
    logic [VALUE_W-1:0]     value_bits_reg, value_bits_next;
    logic [INDEX_OUT_W-1:0] value_index_reg;
    logic                   last_value_reg;

    logic [STORE_W-1:0] stored;
    logic [VALUE_W-1:0] raw;
    logic [HALF_W-1:0]  r32;
    logic [HALF_W-1:0]  z32;
    logic [VALUE_W-1:0] z64;
    logic [HALF_W-1:0]  sum_add;
    logic               emit;

    assign stored = (fwd_valid_reg && (fwd_addr_reg == stg_idx)) ? fwd_data_reg : rd_data;
    assign raw    = {stored, stg_byte};
    assign r32    = raw[HALF_W-1:0];
    assign z32    = {1'b0, r32[HALF_W-1:1]} ^ {HALF_W{r32[0]}};
    assign z64    = {1'b0, raw[VALUE_W-1:1]} ^ {VALUE_W{raw[0]}};
    assign sum_add = sum_reg + z32;

    assign advance = stg.valid && (!stg.final_plane || !out_valid_reg || out_ready);
    assign emit    = advance && stg.final_plane;

    assign wr_en   = advance && !stg.final_plane;
    assign wr_addr = stg_idx;
    assign wr_data = stg.first_plane ? STORE_W'(stg_byte) : {stored[STORE_W-BYTE_W-1:0], stg_byte};

    always_comb
    begin
        case (stg.kind)
            KIND_INT64: value_bits_next = z64;
            KIND_FLOAT: value_bits_next = {{HALF_W{1'b0}}, r32[0], r32[HALF_W-1:1]};
            KIND_REF:   value_bits_next = {{HALF_W{sum_add[HALF_W-1]}}, sum_add};
            default:    value_bits_next = {{HALF_W{z32[HALF_W-1]}}, z32};
        endcase
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (cfg_clear)
        begin
            sum_next = '0;
        end
        else if (emit)
        begin
            if (stg.last_index)
            begin
                sum_next = '0;
            end
            else if (stg.kind == KIND_REF)
            begin
                sum_next = sum_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
        if (emit)
        begin
            value_bits_reg  <= value_bits_next;
            value_index_reg <= INDEX_OUT_W'(stg_idx);
            last_value_reg  <= stg.last_index;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value_bits  = value_bits_reg;
    assign value_index = value_index_reg;
    assign last_value  = last_value_reg;

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        stg.valid && stg.final_plane && out_valid_reg && !out_ready |-> !advance)
        else $error("final-plane transfer advanced into a full output register");

    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        emit && stg.last_index && !cfg_clear |=> sum_reg == '0)
        else $error("running sum not cleared at array end");

    a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> fwd_valid_reg && fwd_addr_reg == $past(wr_addr))
        else $error("forwarding register missed a store write");

    a_no_write_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !wr_en)
        else $error("store written by a completing byte");

endmodule

>>> rtl/byte_plane_array_decoder_unit.sv
// Byte-plane array decoder.
// Input channel (in_valid/in_ready/data_byte) takes one byte per transfer, all
// most significant bytes of the array first, then the next plane, and so on.
// Output channel (out_valid/out_ready) carries value_bits, value_index and
// last_value; a transfer appears for each byte of the last plane only.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// value_count (index 0) or value_kind (index 1); each write restarts the
// array. cfg_ready is always high; write only while the block is idle.
// Throughput: one byte per cycle unless a completing byte waits on a full
// output. A byte reads its partial value from the store in the cycle of its
// transfer and, before the last plane, writes it back in the next, so the
// store read-modify-write sets the rate; a write-back forwarding register
// covers back-to-back bytes of the same entry. A completing byte passes the
// staging register, then the output register, before out_valid rises.
// Reset: counters, running sum and kind clear, value_count goes to one; the
// store is not cleared and needs no clearing pass.
// When out_ready is low, one result is held and bytes that only update the
// store keep flowing; a second completing byte stalls in_ready.
module byte_plane_array_decoder_unit #(
    parameter int MAX_VALUES = bpad_pkg::DEFAULT_MAX_VALUES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  bpad_pkg::reg_index_t                cfg_index,
    input  logic [bpad_pkg::VALUE_COUNT_W-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bpad_pkg::BYTE_W-1:0]         data_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bpad_pkg::VALUE_W-1:0]        value_bits,
    output logic [bpad_pkg::INDEX_OUT_W-1:0]    value_index,
    output logic                                last_value
);

    import bpad_pkg::*;

    localparam int IDX_W = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;

    stage_t             stg;
    logic [IDX_W-1:0]   stg_idx;
    logic [BYTE_W-1:0]  stg_byte;
    logic               advance;
    logic               cfg_clear;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [STORE_W-1:0] rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [STORE_W-1:0] wr_data;

    assign cfg_ready = 1'b1;

    bpad_seq #(
        .MAX_VALUES (MAX_VALUES),
        .IDX_W      (IDX_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .advance   (advance),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .stg       (stg),
        .stg_idx   (stg_idx),
        .stg_byte  (stg_byte),
        .cfg_clear (cfg_clear)
    );

    bpad_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_VALUES),
        .AW    (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bpad_dp #(
        .IDX_W (IDX_W)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .stg         (stg),
        .stg_idx     (stg_idx),
        .stg_byte    (stg_byte),
        .rd_data     (rd_data),
        .cfg_clear   (cfg_clear),
        .advance     (advance),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value_bits  (value_bits),
        .value_index (value_index),
        .last_value  (last_value)
    );

endmodule
